FILE: hdl/gpvd_pkg.sv
// ----------------------------------------------------------------------------
// gpvd_pkg
// Shared constants and types for the 3x3 grid peak/valley detector.
// ----------------------------------------------------------------------------
package gpvd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;
    localparam int COL_BITS    = $clog2(MAX_COLUMNS);
    localparam int CNT_BITS    = 11;   // counts up to 1024 and 0-based positions up to 1023
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    // line store word: {upper, middle}
    localparam int LINE_BITS   = 2 * SAMPLE_BITS;

    // result queue
    localparam int FIFO_DEPTH     = 4;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    // reset and clamp values of the count registers
    localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(100);
    localparam logic [CNT_BITS-1:0] COUNT_MIN   = CNT_BITS'(3);
    localparam logic [CNT_BITS-1:0] ROWS_MAX    = CNT_BITS'(MAX_ROWS);
    localparam logic [CNT_BITS-1:0] COLS_MAX    = CNT_BITS'(MAX_COLUMNS);

    // register indexes (paddr[2])
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // extremum kind codes
    localparam logic KIND_PEAK   = 1'b0;
    localparam logic KIND_VALLEY = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // window test outcome
    typedef struct packed {
        logic found;
        logic kind;
    } ext_flags_t;

    // one result item
    typedef struct packed {
        logic                kind;
        logic [CNT_BITS-1:0] row;
        logic [CNT_BITS-1:0] col;
    } result_t;

endpackage

FILE: hdl/grid_peak_valley_detector_top.sv
// ----------------------------------------------------------------------------
// grid_peak_valley_detector_top
// Strict 3x3 local maxima/minima over a raster stream of elevation samples.
//
//   channel   | direction | handshake                  | payload
//   ----------+-----------+----------------------------+------------------------
//   sample    | in        | sample_valid/sample_stall  | elevation
//   result    | out       | result_valid/result_stall  | extremum_kind,
//             |           |                            | row_number, column_number
//   config    | in        | APB psel/penable/pready    | row_count, column_count
//
// One item per cycle sustained while sample_stall is low. An item is read
// from the line store in the cycle it is accepted and tested the cycle
// after, when the line word comes back; its result is then written into
// the registered result queue and offered on the result channel from there.
// Reset zeroes the positions, loads both counts with 100 and empties the
// result queue; line store and window contents are not cleared and need no
// clearing pass.
// sample_stall rises only when the four-entry result queue plus the item in
// flight could overflow, i.e. after result_stall has held for a while.
// ----------------------------------------------------------------------------
module grid_peak_valley_detector_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample channel
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [gpvd_pkg::SAMPLE_BITS-1:0] elevation,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                extremum_kind,
    output logic [gpvd_pkg::CNT_BITS-1:0]       row_number,
    output logic [gpvd_pkg::CNT_BITS-1:0]       column_number,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gpvd_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [gpvd_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [gpvd_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready
);

    localparam int CB = gpvd_pkg::CNT_BITS;

    // ---------------- configuration registers ----------------
    logic [CB-1:0] row_count_reg;
    logic [CB-1:0] column_count_reg;
    logic          cfg_wr;
    logic          addr_ok;

    assign pready  = 1'b1;
    assign addr_ok = (paddr[1:0] == 2'b00);
    assign cfg_wr  = psel && penable && pwrite && pready && addr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= gpvd_pkg::COUNT_RESET;
            column_count_reg <= gpvd_pkg::COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                gpvd_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[CB-1:0];
                gpvd_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[CB-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        if (addr_ok)
        begin
            case (paddr[2])
                gpvd_pkg::REG_ROW_COUNT:
                    prdata = gpvd_pkg::PDATA_BITS'(row_count_reg);
                gpvd_pkg::REG_COLUMN_COUNT:
                    prdata = gpvd_pkg::PDATA_BITS'(column_count_reg);
                default:
                    prdata = '0;
            endcase
        end
    end

    // counts clamped to their legal ranges
    logic [CB-1:0] used_rows;
    logic [CB-1:0] used_cols;

    always_comb
    begin
        if (row_count_reg < gpvd_pkg::COUNT_MIN)
            used_rows = gpvd_pkg::COUNT_MIN;
        else if (row_count_reg > gpvd_pkg::ROWS_MAX)
            used_rows = gpvd_pkg::ROWS_MAX;
        else
            used_rows = row_count_reg;

        if (column_count_reg < gpvd_pkg::COUNT_MIN)
            used_cols = gpvd_pkg::COUNT_MIN;
        else if (column_count_reg > gpvd_pkg::COLS_MAX)
            used_cols = gpvd_pkg::COLS_MAX;
        else
            used_cols = column_count_reg;
    end

    // ---------------- stage A: accept, position, line read ----------------
    logic [CB-1:0] col_pos_reg, col_pos_next;
    logic [CB-1:0] row_pos_reg, row_pos_next;
    logic [CB-1:0] cur_col;
    logic [CB-1:0] cur_row;
    logic [CB-1:0] row_step;
    logic [CB-1:0] nxt_col;
    logic [CB-1:0] nxt_row;
    logic          col_wrap;
    logic          nxt_wrap;
    logic          accept;

    logic [gpvd_pkg::FIFO_CNT_BITS-1:0] q_count;
    logic                               s1_valid_reg;

    // room for everything already in flight plus this item
    assign sample_stall = (q_count + gpvd_pkg::FIFO_CNT_BITS'(s1_valid_reg))
                          >= gpvd_pkg::FIFO_CNT_BITS'(gpvd_pkg::FIFO_DEPTH);
    assign accept       = sample_valid && !sample_stall;

    // the position is wrapped after each item with the counts in force, and
    // again on use, so a count lowered while idle is honored at the next item
    always_comb
    begin
        col_wrap     = (col_pos_reg >= used_cols);
        cur_col      = col_wrap ? '0 : col_pos_reg;
        row_step     = col_wrap ? row_pos_reg + 1'b1 : row_pos_reg;
        cur_row      = (row_step >= used_rows) ? '0 : row_step;
        nxt_col      = cur_col + 1'b1;
        nxt_wrap     = (nxt_col >= used_cols);
        nxt_row      = nxt_wrap ? cur_row + 1'b1 : cur_row;
        col_pos_next = accept ? (nxt_wrap ? '0 : nxt_col) : col_pos_reg;
        row_pos_next = accept ? ((nxt_row >= used_rows) ? '0 : nxt_row) : row_pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else
        begin
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
        end
    end

    // stage A -> B payload
    gpvd_pkg::sample_t                s1_sample_reg;
    logic [CB-1:0]                    s1_col_reg;
    logic [CB-1:0]                    s1_row_reg;
    logic                             s1_test_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= elevation;
            s1_col_reg    <= cur_col;
            s1_row_reg    <= cur_row;
            s1_test_reg   <= (cur_row >= CB'(2)) && (cur_col >= CB'(2));
        end
    end

    // ---------------- line store ----------------
    // word layout {upper, middle}; stage B writes back {old middle, sample}
    logic [gpvd_pkg::LINE_BITS-1:0] line_rd;
    logic [gpvd_pkg::LINE_BITS-1:0] line_wr;
    gpvd_pkg::sample_t              line_upper;
    gpvd_pkg::sample_t              line_middle;

    assign line_upper  = line_rd[gpvd_pkg::LINE_BITS-1:gpvd_pkg::SAMPLE_BITS];
    assign line_middle = line_rd[gpvd_pkg::SAMPLE_BITS-1:0];
    assign line_wr     = {line_middle, s1_sample_reg};

    gpvd_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_col[gpvd_pkg::COL_BITS-1:0]),
        .rd_data (line_rd),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg[gpvd_pkg::COL_BITS-1:0]),
        .wr_data (line_wr)
    );

    // ---------------- stage B: window shift and test ----------------
    gpvd_pkg::ext_flags_t flags;

    gpvd_window u_window (
        .clk     (clk),
        .load    (s1_valid_reg),
        .upper   (line_upper),
        .middle  (line_middle),
        .sample  (s1_sample_reg),
        .test_en (s1_valid_reg && s1_test_reg),
        .flags   (flags)
    );

    // ---------------- result queue ----------------
    gpvd_pkg::result_t push_item;
    gpvd_pkg::result_t head_item;
    logic              q_push;
    logic              q_pop;

    assign push_item.kind = flags.kind;
    assign push_item.row  = s1_row_reg;
    assign push_item.col  = s1_col_reg;
    assign q_push         = flags.found;
    assign q_pop          = result_valid && !result_stall;

    gpvd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_item),
        .pop       (q_pop),
        .head      (head_item),
        .count     (q_count)
    );

    assign result_valid  = (q_count != '0);
    assign extremum_kind = head_item.kind;
    assign row_number    = head_item.row;
    assign column_number = head_item.col;

`ifndef NO_ASSERTIONS
    // back-to-back items never touch the same column, so the line store
    // needs no forwarding
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (cur_col != s1_col_reg))
        else $error("line store read and write hit the same column");

    // the stall must keep the result queue from overflowing
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= gpvd_pkg::FIFO_CNT_BITS'(gpvd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // only points with row and column of at least 2 are ever reported
    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (s1_row_reg >= CB'(2)) && (s1_col_reg >= CB'(2)))
        else $error("result for a border point");

    // a result is pushed only in the cycle after an item was accepted
    a_push_source: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> $past(accept))
        else $error("result without an accepted item");
`endif

endmodule

FILE: hdl/gpvd_line_mem.sv
// ----------------------------------------------------------------------------
// gpvd_line_mem
// Line store: one word per column holding the upper and middle row samples.
// Synchronous, registered read port; one write port.
// ----------------------------------------------------------------------------
module gpvd_line_mem (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [gpvd_pkg::COL_BITS-1:0] rd_addr,
    output logic [gpvd_pkg::LINE_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [gpvd_pkg::COL_BITS-1:0] wr_addr,
    input  logic [gpvd_pkg::LINE_BITS-1:0] wr_data
);

    logic [gpvd_pkg::LINE_BITS-1:0] mem [gpvd_pkg::MAX_COLUMNS];
    logic [gpvd_pkg::LINE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/gpvd_window.sv
// ----------------------------------------------------------------------------
// gpvd_window
// 3x3 sample window. Shifts in one column per item and tests the centre of
// the shifted window against its eight neighbours.
// ----------------------------------------------------------------------------
module gpvd_window (
    input  logic                 clk,
    input  logic                 load,
    input  gpvd_pkg::sample_t    upper,
    input  gpvd_pkg::sample_t    middle,
    input  gpvd_pkg::sample_t    sample,
    input  logic                 test_en,
    output gpvd_pkg::ext_flags_t flags
);

    // win_reg[row*3 + col], col 2 is the newest column
    gpvd_pkg::sample_t win_reg [9];
    gpvd_pkg::sample_t nbr [8];
    gpvd_pkg::sample_t centre;
    logic              above;
    logic              below;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= upper;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= middle;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= sample;
        end
    end

    // neighbours of the window after this shift; centre is current col 2
    always_comb
    begin
        centre = win_reg[5];
        nbr[0] = win_reg[1];
        nbr[1] = win_reg[2];
        nbr[2] = upper;
        nbr[3] = win_reg[4];
        nbr[4] = middle;
        nbr[5] = win_reg[7];
        nbr[6] = win_reg[8];
        nbr[7] = sample;
        above  = 1'b1;
        below  = 1'b1;
        for (int k = 0; k < 8; k++)
        begin
            if (!(nbr[k] < centre))
            begin
                above = 1'b0;
            end
            if (!(nbr[k] > centre))
            begin
                below = 1'b0;
            end
        end
        flags.found = test_en && (above || below);
        flags.kind  = above ? gpvd_pkg::KIND_PEAK : gpvd_pkg::KIND_VALLEY;
    end

endmodule

FILE: hdl/gpvd_out_fifo.sv
// ----------------------------------------------------------------------------
// gpvd_out_fifo
// Small result queue between the detector pipeline and the output channel.
// ----------------------------------------------------------------------------
module gpvd_out_fifo (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  gpvd_pkg::result_t                  push_data,
    input  logic                               pop,
    output gpvd_pkg::result_t                  head,
    output logic [gpvd_pkg::FIFO_CNT_BITS-1:0] count
);

    gpvd_pkg::result_t                  entry_reg [gpvd_pkg::FIFO_DEPTH];
    logic [gpvd_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gpvd_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gpvd_pkg::FIFO_CNT_BITS-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + gpvd_pkg::FIFO_CNT_BITS'(push)
                                - gpvd_pkg::FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule
